FILE: src/refcounted_page_allocator_defines.svh
// Assertion helpers used by the allocator datapath.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("page allocator check failed");

// Next-cycle implication, checked outside reset.
`define RPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("page allocator check failed");

`endif

FILE: src/rpa_pkg.sv
package rpa_pkg;

  // Fixed field widths of the stream and register interfaces.
  localparam int unsigned PAGE_W   = 12;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned REF_W    = 8;
  localparam int unsigned FREE_W   = 13;
  localparam int unsigned LIMIT_W  = 13;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // Default sizing of the allocator.
  localparam int unsigned DEF_PAGES      = 4096;
  localparam int unsigned DEF_COUNT_BITS = 8;

  // Register reset values.
  localparam logic [PAGE_W-1:0]  FIRST_PAGE_RST = '0;
  localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RST = 13'h1000;

  // Register byte addresses.
  localparam logic [APB_AW-1:0] ADDR_FIRST_PAGE = 3'd0;
  localparam logic [APB_AW-1:0] ADDR_PAGE_LIMIT = 3'd4;

  // Operation codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 3'd0,
    MODE_FREE  = 3'd1,
    MODE_SEED  = 3'd2,
    MODE_INC   = 3'd3,
    MODE_DEC   = 3'd4,
    MODE_QUERY = 3'd5
  } mode_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_EMPTY = 3'd1,
    STAT_BAD   = 3'd2,
    STAT_UNDER = 3'd3,
    STAT_OVER  = 3'd4,
    STAT_FULL  = 3'd5
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic commit;
  } rpa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic out_busy;
  } rpa_stat_t;

endpackage

FILE: src/rpa_ctrl.sv
module rpa_ctrl
  import rpa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  output rpa_cmd_t  cmd_o,
  input  rpa_stat_t stat_i
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  // Command decode from the current state.
  always_comb begin
    s_tready_o       = (state_q == ST_IDLE);
    cmd_o.clear_step = (state_q == ST_CLEAR);
    cmd_o.accept     = (state_q == ST_IDLE) && s_tvalid_i;
    cmd_o.commit     = (state_q == ST_EXEC) && !stat_i.out_busy;
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (!stat_i.out_busy) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // State register; the count memory is swept after every reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/rpa_datapath.sv
`include "refcounted_page_allocator_defines.svh"

module rpa_datapath
  import rpa_pkg::*;
#(
  parameter int unsigned PAGES      = DEF_PAGES,
  parameter int unsigned COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rpa_cmd_t              cmd_i,
  output rpa_stat_t             stat_o,
  input  logic [MODE_W-1:0]     mode_i,
  input  logic [PAGE_W-1:0]     page_i,
  input  logic [PAGE_W-1:0]     first_page_i,
  input  logic [LIMIT_W-1:0]    page_limit_i,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0] m_tdata_o
);

  localparam int unsigned PAGE_AW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned TOP_W   = $clog2(PAGES + 1);

  // Map a page number onto a memory index of the configured depth.
  function automatic logic [PAGE_AW-1:0] page_idx(input logic [PAGE_W-1:0] pg);
    logic [PAGE_AW+PAGE_W-1:0] ext;
    ext = {{PAGE_AW{1'b0}}, pg};
    return ext[PAGE_AW-1:0];
  endfunction

  // Storage: count table, free stack and their bookkeeping.
  logic [COUNT_BITS-1:0] count_mem [PAGES];
  logic [PAGE_W-1:0]     stack_mem [PAGES];
  logic [TOP_W-1:0]      top_q, top_d;
  logic [PAGE_AW-1:0]    clr_idx_q;
  logic [MODE_W-1:0]     mode_q;
  logic [PAGE_W-1:0]     page_q;
  logic [COUNT_BITS-1:0] cnt_rd_q;
  logic [PAGE_W-1:0]     stk_rd_q;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  // Operation results.
  logic                  op_cnt_we;
  logic [PAGE_AW-1:0]    op_cnt_wa;
  logic [COUNT_BITS-1:0] op_cnt_wd;
  logic                  op_push;
  logic [PAGE_W-1:0]     granted;
  status_e               status;
  logic [COUNT_BITS-1:0] cnt_out;
  logic                  in_table;
  logic                  in_range;
  logic [31:0]           page_wide;
  logic [TOP_W-1:0]      top_m1;

  // Memory port controls.
  logic                  cnt_we;
  logic [PAGE_AW-1:0]    cnt_wa;
  logic [COUNT_BITS-1:0] cnt_wd;
  logic                  stk_we;

  // Output field extension.
  logic [COUNT_BITS+REF_W-1:0] ref_ext;
  logic [TOP_W+FREE_W-1:0]     free_ext;

  assign top_m1    = top_q - TOP_W'(1);
  assign page_wide = 32'(page_q);
  assign in_table  = page_wide < 32'(PAGES);
  assign in_range  = in_table && (page_q >= first_page_i) &&
                     ({1'b0, page_q} < page_limit_i);

  // Decide the effect of the held operation on the counts and the stack.
  always_comb begin
    op_cnt_we = 1'b0;
    op_cnt_wa = page_idx(page_q);
    op_cnt_wd = cnt_rd_q;
    op_push   = 1'b0;
    granted   = '0;
    status    = STAT_OK;
    cnt_out   = '0;
    top_d     = top_q;
    case (mode_e'(mode_q))
      MODE_ALLOC: begin
        if (top_q == '0) begin
          status = STAT_EMPTY;
        end else begin
          granted   = stk_rd_q;
          op_cnt_we = 1'b1;
          op_cnt_wa = page_idx(stk_rd_q);
          op_cnt_wd = COUNT_BITS'(1);
          cnt_out   = COUNT_BITS'(1);
          top_d     = top_m1;
        end
      end
      MODE_FREE, MODE_SEED: begin
        if (!in_range) begin
          status = STAT_BAD;
        end else begin
          if (mode_e'(mode_q) == MODE_SEED) begin
            op_cnt_wd = '0;
          end else if (cnt_rd_q != '0) begin
            op_cnt_wd = cnt_rd_q - COUNT_BITS'(1);
          end
          op_cnt_we = 1'b1;
          cnt_out   = op_cnt_wd;
          // A count that lands on zero puts the page back on the stack.
          if (op_cnt_wd == '0) begin
            if (top_q >= TOP_W'(PAGES)) begin
              status = STAT_FULL;
            end else begin
              op_push = 1'b1;
              top_d   = top_q + TOP_W'(1);
            end
          end
        end
      end
      default: begin
        // Increment, decrement, query; unused codes behave as query.
        if (!in_table) begin
          status = STAT_BAD;
        end else if (mode_e'(mode_q) == MODE_INC) begin
          if (cnt_rd_q == '1) begin
            status = STAT_OVER;
          end else begin
            op_cnt_we = 1'b1;
            op_cnt_wd = cnt_rd_q + COUNT_BITS'(1);
          end
          cnt_out = op_cnt_wd;
        end else if (mode_e'(mode_q) == MODE_DEC) begin
          if (cnt_rd_q == '0) begin
            status = STAT_UNDER;
          end else begin
            op_cnt_we = 1'b1;
            op_cnt_wd = cnt_rd_q - COUNT_BITS'(1);
          end
          cnt_out = op_cnt_wd;
        end else begin
          cnt_out = cnt_rd_q;
        end
      end
    endcase
  end

  // Count memory write port is shared by the clearing sweep and the operations.
  assign cnt_we = cmd_i.clear_step || (cmd_i.commit && op_cnt_we);
  assign cnt_wa = cmd_i.clear_step ? clr_idx_q : op_cnt_wa;
  assign cnt_wd = cmd_i.clear_step ? '0 : op_cnt_wd;
  assign stk_we = cmd_i.commit && op_push;

  // Count memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      count_mem[cnt_wa] <= cnt_wd;
    end
    if (cmd_i.accept) begin
      cnt_rd_q <= count_mem[page_idx(page_i)];
    end
  end

  // Free stack memory: push at the top, read the entry below it for a pop.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[top_q[PAGE_AW-1:0]] <= page_q;
    end
    if (cmd_i.accept) begin
      stk_rd_q <= stack_mem[top_m1[PAGE_AW-1:0]];
    end
  end

  // Operation capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q <= mode_i;
      page_q <= page_i;
    end
  end

  // Stack pointer and clearing sweep index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q     <= '0;
      clr_idx_q <= '0;
    end else begin
      if (cmd_i.commit) top_q <= top_d;
      if (cmd_i.clear_step) clr_idx_q <= clr_idx_q + PAGE_AW'(1);
    end
  end

  assign ref_ext  = {{REF_W{1'b0}}, cnt_out};
  assign free_ext = {{FREE_W{1'b0}}, top_d};

  // Output register holds one result beat until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= {4'b0, free_ext[FREE_W-1:0], ref_ext[REF_W-1:0], status, granted};
    end
  end

  assign m_tvalid_o        = out_valid_q;
  assign m_tdata_o         = out_data_q;
  assign stat_o.out_busy   = out_valid_q && !m_tready_i;
  assign stat_o.clear_last = (clr_idx_q == PAGE_AW'(PAGES - 1));

  // The stack never holds more pages than the table has.
  `RPA_ASSERT_IMP(a_top_bound, clk_i, rst_ni, 1'b1, top_q <= TOP_W'(PAGES))
  // A result is never written over one the sink has not taken.
  `RPA_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, cmd_i.commit, !(out_valid_q && !m_tready_i))
  // A finished operation always shows up on the output.
  `RPA_ASSERT_NEXT(a_commit_shows, clk_i, rst_ni, cmd_i.commit, out_valid_q)
  // The stack pointer moves only when an operation finishes.
  `RPA_ASSERT_NEXT(a_top_quiet, clk_i, rst_ni, !cmd_i.commit, $stable(top_q))

endmodule

FILE: src/refcounted_page_allocator.sv
// Flow: an accepted operation is captured, then committed once the output is
// free, and its result beat is registered. No new operation is taken until the
// last commits, a read-then-write pass over the count memory and the free stack
// memory; a stalled output holds it. Reset: the free stack empties, registers
// return to their reset values, and a sweep zeroes the counts, s_tready held low.
module refcounted_page_allocator
  import rpa_pkg::*;
#(
  parameter int unsigned PAGES      = DEF_PAGES,
  parameter int unsigned COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Operation stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [11:0] page, rest zero
  input  logic [MODE_W-1:0]     s_tuser,   // [2:0] mode
  // Result stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [11:0] granted_page, [14:12] status,
                                           // [22:15] ref_count, [35:23] free_pages
  // Register port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready
);

  logic [PAGE_W-1:0]  first_page_q;
  logic [LIMIT_W-1:0] page_limit_q;
  logic               cfg_wr;
  rpa_cmd_t           cmd;
  rpa_stat_t          stat;

  // Register writes complete in the access phase; the port never waits.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_page_q <= FIRST_PAGE_RST;
      page_limit_q <= PAGE_LIMIT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == ADDR_PAGE_LIMIT[2]) begin
        page_limit_q <= pwdata[LIMIT_W-1:0];
      end else begin
        first_page_q <= pwdata[PAGE_W-1:0];
      end
    end
  end

  // Register read-back.
  always_comb begin
    if (paddr[2] == ADDR_FIRST_PAGE[2]) begin
      prdata = {{(APB_DW-PAGE_W){1'b0}}, first_page_q};
    end else begin
      prdata = {{(APB_DW-LIMIT_W){1'b0}}, page_limit_q};
    end
  end

  rpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  rpa_datapath #(
    .PAGES      (PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .mode_i       (s_tuser),
    .page_i       (s_tdata[PAGE_W-1:0]),
    .first_page_i (first_page_q),
    .page_limit_i (page_limit_q),
    .m_tvalid_o   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_o    (m_tdata)
  );

endmodule

FILE: sim/tb_refcounted_page_allocator.sv
`timescale 1ns / 1ps

module tb_refcounted_page_allocator;
  import rpa_pkg::*;

  localparam int unsigned PAGES = DEF_PAGES;
  localparam int unsigned COUNT_MAX = (1 << DEF_COUNT_BITS) - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int REPORT_LIMIT = 10;

  // Modes without an operation of their own; the block treats them as a query.
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

  // Register indexes, in the order of the register map.
  localparam logic [2:0] REG_FIRST_PAGE = 3'd0;
  localparam logic [2:0] REG_PAGE_LIMIT = 3'd1;

  // One result beat, unpacked into its fields.
  typedef struct packed {
    logic [PAGE_W-1:0] granted;
    status_e           status;
    logic [REF_W-1:0]  refs;
    logic [FREE_W-1:0] free_pages;
  } alloc_result_t;

  // One line of the directed plan: an operation repeated reps times, or a
  // register write. Typed lines carry their expected result.
  typedef struct packed {
    bit                 is_write;
    logic [2:0]         md;
    logic [LIMIT_W-1:0] arg;
    int                 reps;
    bit                 typed;
    alloc_result_t      want;
  } plan_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [MODE_W-1:0]     s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  // Shadow copy of the allocator state.
  logic [DEF_COUNT_BITS-1:0] page_refs [PAGES];
  logic [PAGE_W-1:0]         free_list [PAGES];
  int unsigned               free_depth;
  logic [PAGE_W-1:0]         cfg_first;
  logic [LIMIT_W-1:0]        cfg_limit;

  alloc_result_t     pending_results [$];
  logic [PAGE_W-1:0] live_pages [$];
  plan_row_t         plan [$];

  // Expectation that the sender attaches to the beat it is offering.
  bit            beat_typed;
  alloc_result_t beat_want;

  bit gaps_on;
  bit sink_idle_on;
  bit sink_hold_req;

  int mismatches;
  int ops_accepted;
  int results_checked;
  int reg_writes;
  int cycle_count;
  int status_seen [8];

  refcounted_page_allocator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Applies one operation to the shadow state and returns the result it gives.
  function automatic alloc_result_t allocator_outcome(input logic [MODE_W-1:0] md,
                                                      input logic [PAGE_W-1:0] pg);
    alloc_result_t r;
    logic          in_range;
    r = '0;
    r.status = STAT_OK;
    in_range = (pg >= cfg_first) && ({1'b0, pg} < cfg_limit);
    case (md)
      MODE_ALLOC: begin
        if (free_depth == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          free_depth--;
          r.granted = free_list[free_depth];
          page_refs[r.granted] = 1;
          r.refs = 1;
        end
      end
      MODE_FREE, MODE_SEED: begin
        if (!in_range) begin
          r.status = STAT_BAD;
        end else begin
          if (md == MODE_SEED) begin
            page_refs[pg] = 0;
          end else if (page_refs[pg] != 0) begin
            page_refs[pg]--;
          end
          r.refs = REF_W'(page_refs[pg]);
          // A page whose count is zero goes back on the stack, room permitting.
          if (page_refs[pg] == 0) begin
            if (free_depth >= PAGES) begin
              r.status = STAT_FULL;
            end else begin
              free_list[free_depth] = pg;
              free_depth++;
            end
          end
        end
      end
      MODE_INC: begin
        if (page_refs[pg] >= COUNT_MAX) begin
          r.status = STAT_OVER;
        end else begin
          page_refs[pg]++;
        end
        r.refs = REF_W'(page_refs[pg]);
      end
      MODE_DEC: begin
        if (page_refs[pg] == 0) begin
          r.status = STAT_UNDER;
        end else begin
          page_refs[pg]--;
        end
        r.refs = REF_W'(page_refs[pg]);
      end
      default: begin
        r.refs = REF_W'(page_refs[pg]);
      end
    endcase
    r.free_pages = FREE_W'(free_depth);
    return r;
  endfunction

  function automatic plan_row_t op_row(input logic [MODE_W-1:0] md,
                                       input logic [PAGE_W-1:0] pg, input int reps);
    plan_row_t row;
    row = '0;
    row.md = md;
    row.arg = LIMIT_W'(pg);
    row.reps = reps;
    return row;
  endfunction

  function automatic plan_row_t chk_row(input logic [MODE_W-1:0] md,
                                        input logic [PAGE_W-1:0] pg,
                                        input logic [PAGE_W-1:0] granted, input status_e st,
                                        input logic [REF_W-1:0] refs,
                                        input logic [FREE_W-1:0] free_pages);
    plan_row_t row;
    row = op_row(md, pg, 1);
    row.typed = 1'b1;
    row.want.granted = granted;
    row.want.status = st;
    row.want.refs = refs;
    row.want.free_pages = free_pages;
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic [2:0] idx, input logic [LIMIT_W-1:0] value);
    plan_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.md = idx;
    row.arg = value;
    return row;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("Mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  // Scoreboard: checks each result beat, then predicts each accepted operation.
  always @(posedge clk_i) begin : scoreboard
    alloc_result_t got;
    alloc_result_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got.granted = m_tdata[11:0];
        got.status = status_e'(m_tdata[14:12]);
        got.refs = m_tdata[22:15];
        got.free_pages = m_tdata[35:23];
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("result beat with none expected: page %0d status %0d",
                                  got.granted, got.status));
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (got.granted !== want.granted || got.status !== want.status ||
              got.refs !== want.refs || got.free_pages !== want.free_pages) begin
            flag_mismatch($sformatf(
              "expected page %0d status %0d refs %0d free %0d, got %0d %0d %0d %0d",
              want.granted, want.status, want.refs, want.free_pages,
              got.granted, got.status, got.refs, got.free_pages));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = allocator_outcome(s_tuser, s_tdata[PAGE_W-1:0]);
        if (beat_typed) begin
          want = beat_want;
        end
        pending_results.push_back(want);
        ops_accepted++;
        status_seen[want.status]++;
        // Remember handed-out pages so later operations act on live ones.
        if (s_tuser == MODE_ALLOC && want.status == STAT_OK) begin
          live_pages.push_back(want.granted);
          if (live_pages.size() > 48) begin
            void'(live_pages.pop_front());
          end
        end
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_req) begin
        m_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk_i);
        sink_hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offers one operation beat, starting and ending at a falling edge.
  task automatic put_op(input logic [MODE_W-1:0] md, input logic [PAGE_W-1:0] pg,
                        input bit typed, input alloc_result_t want);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    beat_typed = typed;
    beat_want = want;
    s_tvalid <= 1'b1;
    s_tuser <= md;
    s_tdata <= {{(IN_DATA_W - PAGE_W){1'b0}}, pg};
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  // Stops offering beats and waits until every expected result has come.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // One APB transfer: setup phase, access phase, then idle with psel low.
  task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Writes a register, mirrors it in the shadow state and reads it back.
  task automatic set_reg(input logic [2:0] idx, input logic [LIMIT_W-1:0] value);
    logic [APB_DW-1:0] rd;
    logic [APB_DW-1:0] stored;
    logic [APB_AW-1:0] addr;
    if (idx == REG_FIRST_PAGE) begin
      addr = ADDR_FIRST_PAGE;
      cfg_first = value[PAGE_W-1:0];
      stored = APB_DW'(cfg_first);
    end else begin
      addr = ADDR_PAGE_LIMIT;
      cfg_limit = value;
      stored = APB_DW'(cfg_limit);
    end
    apb_access(1'b1, addr, APB_DW'(value), rd);
    apb_access(1'b0, addr, '0, rd);
    reg_writes++;
    if (rd !== stored) begin
      flag_mismatch($sformatf("register at %0d reads %0h, expected %0h", addr, rd, stored));
    end
  endtask

  // Random operation, mostly on live pages or pages inside the window.
  task automatic random_op();
    logic [MODE_W-1:0] md;
    logic [PAGE_W-1:0] pg;
    int                pick;
    int                span;
    pick = $urandom_range(0, 99);
    if (pick < 25) md = MODE_ALLOC;
    else if (pick < 45) md = MODE_FREE;
    else if (pick < 60) md = MODE_SEED;
    else if (pick < 75) md = MODE_INC;
    else if (pick < 87) md = MODE_DEC;
    else if (pick < 95) md = MODE_QUERY;
    else if (pick[0]) md = MODE_SPARE7;
    else md = MODE_SPARE6;
    span = (cfg_limit > cfg_first) ? int'(cfg_limit) - int'(cfg_first) : 1;
    pick = $urandom_range(0, 99);
    if (pick < 55 && live_pages.size() > 0) begin
      pg = live_pages[$urandom_range(0, live_pages.size() - 1)];
    end else if (pick < 80) begin
      pg = PAGE_W'(int'(cfg_first) + $urandom_range(0, span - 1));
    end else if (pick < 90) begin
      // Just inside and just outside the window.
      case ($urandom_range(0, 3))
        0: pg = cfg_first - 1'b1;
        1: pg = cfg_first;
        2: pg = PAGE_W'(cfg_limit - 1'b1);
        default: pg = PAGE_W'(cfg_limit);
      endcase
    end else begin
      pg = PAGE_W'($urandom());
    end
    put_op(md, pg, 1'b0, '0);
  endtask

  task automatic random_phase(input logic [PAGE_W-1:0] first, input logic [LIMIT_W-1:0] limit,
                              input int count, input bit hold_off);
    settle();
    set_reg(REG_FIRST_PAGE, LIMIT_W'(first));
    set_reg(REG_PAGE_LIMIT, limit);
    if (hold_off) begin
      sink_hold_req = 1'b1;
    end
    repeat (count) random_op();
  endtask

  initial begin : stimulus
    rst_ni = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = MODE_ALLOC;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    beat_typed = 1'b0;
    beat_want = '0;
    gaps_on = 1'b1;
    sink_idle_on = 1'b1;
    sink_hold_req = 1'b0;
    mismatches = 0;
    ops_accepted = 0;
    results_checked = 0;
    reg_writes = 0;
    cycle_count = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (page_refs[i]) page_refs[i] = '0;
    foreach (free_list[i]) free_list[i] = '0;
    free_depth = 0;
    cfg_first = FIRST_PAGE_RST;
    cfg_limit = PAGE_LIMIT_RST;

    // Directed plan: empty stack, LIFO order, double free, saturation,
    // window edges at both extremes, and the unused modes.
    plan.push_back(chk_row(MODE_ALLOC, 12'h000, 12'h000, STAT_EMPTY, 8'd0, 13'd0));
    plan.push_back(chk_row(MODE_QUERY, 12'hFFF, 12'h000, STAT_OK, 8'd0, 13'd0));
    plan.push_back(chk_row(MODE_DEC, 12'h000, 12'h000, STAT_UNDER, 8'd0, 13'd0));
    plan.push_back(chk_row(MODE_SEED, 12'hFFF, 12'h000, STAT_OK, 8'd0, 13'd1));
    plan.push_back(chk_row(MODE_SEED, 12'h000, 12'h000, STAT_OK, 8'd0, 13'd2));
    plan.push_back(chk_row(MODE_ALLOC, 12'hABC, 12'h000, STAT_OK, 8'd1, 13'd1));
    plan.push_back(op_row(MODE_INC, 12'h000, 1));
    plan.push_back(op_row(MODE_FREE, 12'h000, 3));
    plan.push_back(op_row(MODE_ALLOC, 12'h555, 3));
    plan.push_back(op_row(MODE_SPARE6, 12'hAAA, 1));
    plan.push_back(op_row(MODE_SPARE7, 12'h555, 1));
    plan.push_back(op_row(MODE_INC, 12'h800, 256));
    plan.push_back(chk_row(MODE_QUERY, 12'h800, 12'h000, STAT_OK, 8'd255, 13'd0));
    plan.push_back(op_row(MODE_DEC, 12'h800, 3));
    plan.push_back(reg_row(REG_FIRST_PAGE, 13'h0100));
    plan.push_back(reg_row(REG_PAGE_LIMIT, 13'h0200));
    plan.push_back(chk_row(MODE_FREE, 12'h0FF, 12'h000, STAT_BAD, 8'd0, 13'd0));
    plan.push_back(chk_row(MODE_SEED, 12'h200, 12'h000, STAT_BAD, 8'd0, 13'd0));
    plan.push_back(op_row(MODE_SEED, 12'h1FF, 1));
    plan.push_back(op_row(MODE_SEED, 12'h100, 1));
    plan.push_back(op_row(MODE_INC, 12'h0FF, 1));
    plan.push_back(reg_row(REG_FIRST_PAGE, 13'h0FFF));
    plan.push_back(reg_row(REG_PAGE_LIMIT, 13'h1000));
    plan.push_back(op_row(MODE_SEED, 12'hFFF, 1));
    plan.push_back(chk_row(MODE_SEED, 12'hFFE, 12'h000, STAT_BAD, 8'd0, 13'd3));
    plan.push_back(reg_row(REG_FIRST_PAGE, 13'h0000));
    plan.push_back(reg_row(REG_PAGE_LIMIT, 13'h0001));
    plan.push_back(chk_row(MODE_SEED, 12'h000, 12'h000, STAT_OK, 8'd0, 13'd4));
    plan.push_back(chk_row(MODE_SEED, 12'h001, 12'h000, STAT_BAD, 8'd0, 13'd4));
    plan.push_back(op_row(MODE_FREE, 12'hFFF, 1));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // The count memory is cleared after reset; input ready marks the end.
    while (!s_tready) @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        settle();
        set_reg(plan[i].md, plan[i].arg);
      end else begin
        repeat (plan[i].reps) begin
          put_op(plan[i].md, plan[i].arg[PAGE_W-1:0], plan[i].typed, plan[i].want);
        end
      end
    end

    // Random phases over several windows; the second starts with a long
    // receiver hold-off so the block backs up onto its input.
    random_phase(12'h000, 13'h1000, 75, 1'b0);
    random_phase(12'h040, 13'h00C0, 75, 1'b1);
    random_phase(12'hF00, 13'h1000, 75, 1'b0);
    settle();
    gaps_on = 1'b0;
    sink_idle_on = 1'b0;
    random_phase(12'h000, 13'h0800, 75, 1'b0);

    // A few edge operations over the full window, then a short random tail.
    random_phase(12'h000, 13'h1000, 0, 1'b0);
    settle();
    put_op(MODE_SEED, 12'hFFF, 1'b0, '0);
    put_op(MODE_FREE, 12'h000, 1'b0, '0);
    put_op(MODE_ALLOC, 12'h000, 1'b0, '0);
    put_op(MODE_SEED, 12'h123, 1'b0, '0);
    put_op(MODE_SEED, 12'h123, 1'b0, '0);
    repeat (20) random_op();

    settle();
    repeat (8) @(negedge clk_i);
    $display("Covered %0d operations and %0d checked results across %0d register writes.",
             ops_accepted, results_checked, reg_writes);
    $display("Status mix: ok %0d, empty %0d, bad page %0d, underflow %0d, overflow %0d, full %0d.",
             status_seen[STAT_OK], status_seen[STAT_EMPTY], status_seen[STAT_BAD],
             status_seen[STAT_UNDER], status_seen[STAT_OVER], status_seen[STAT_FULL]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: refcounted_page_allocator.f
+incdir+src
src/rpa_pkg.sv
src/rpa_ctrl.sv
src/rpa_datapath.sv
src/refcounted_page_allocator.sv
sim/tb_refcounted_page_allocator.sv
